/* design/smpc_pkg.sv */
// shared constants for the soil moisture pump controller core
// phase codes, register indexes, reset values and the percent scale; no dependencies
package smpc_pkg;

  localparam int ADC_W    = 12;
  localparam int PCT_W    = 7;
  localparam int SEC_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PCT_SCALE = 100;

  localparam logic [1:0] PH_SAMPLING = 2'd0;
  localparam logic [1:0] PH_PUMPING  = 2'd1;
  localparam logic [1:0] PH_WAITING  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DRY_RAW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_RAW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TRIGGER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS   = 3'd5;

  localparam logic [ADC_W-1:0] DRY_RAW_RST      = 12'd4095;
  localparam logic [ADC_W-1:0] WET_RAW_RST      = 12'd0;
  localparam logic [PCT_W-1:0] LOW_TRIGGER_RST  = 7'd30;
  localparam logic [PCT_W-1:0] TARGET_LEVEL_RST = 7'd60;
  localparam logic [SEC_W-1:0] PUMP_TICKS_RST   = 16'd5;
  localparam logic [SEC_W-1:0] WAIT_TICKS_RST   = 16'd60;

  localparam int OP_TICK   = 0;
  localparam int OP_SAMPLE = 1;

  // shared divider: numerator and shifted divisor width
  localparam int DIV_W = 19;
  localparam int DIV_STEPS = PCT_W;

endpackage

/* design/soil_moisture_pump_controller_core.sv */
// soil moisture pump controller core: hysteresis watering control with one shared divider
// depends on smpc_pkg
// throughput: one transaction at a time, s_tready returns in the same cycle m_tvalid rises;
//   a result still waiting in the output register holds the next one back before its push
// reset: synchronous, clears store, average, phase and tick count, loads register defaults
module soil_moisture_pump_controller_core #(
  parameter int SENSOR_COUNT = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,  // sensor_index, adc_value
  input  logic                               s_tuser,  // opcode
  input  logic                               s_tlast,  // last_sample
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pump_on, sensor_power, phase, watering, mean_level, sample_percent
  output logic [23:0]                        m_tdata,
  output logic                               m_tuser,  // sample_valid
  input  logic                               cfg_we,
  input  logic [smpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import smpc_pkg::*;

  localparam int WW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int AW = $clog2(SENSOR_COUNT * PCT_SCALE + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PREP    = 3'd1;
  localparam logic [2:0] S_DIV_PCT = 3'd2;
  localparam logic [2:0] S_SUM     = 3'd3;
  localparam logic [2:0] S_DIV_AVG = 3'd4;
  localparam logic [2:0] S_DECIDE  = 3'd5;
  localparam logic [2:0] S_TICK    = 3'd6;
  localparam logic [2:0] S_PUSH    = 3'd7;

  logic [2:0] state;

  logic [ADC_W-1:0] dry_raw, wet_raw;
  logic [PCT_W-1:0] low_trigger, target_level;
  logic [SEC_W-1:0] pump_ticks, wait_ticks;

  logic [PCT_W-1:0] moisture_store [SENSOR_COUNT];
  logic [PCT_W-1:0] average_level;
  logic [1:0]       control_phase;
  logic             watering_active;
  logic [SEC_W-1:0] tick_count;

  logic [1:0]       in_idx;
  logic [ADC_W-1:0] in_adc;
  logic             in_last;

  logic             sample_valid;
  logic [PCT_W-1:0] sample_percent;

  logic [WW-1:0]    walk;
  logic [AW-1:0]    acc;
  logic [AW-1:0]    acc_next;

  logic [DIV_W-1:0] rem, dsh;
  logic [PCT_W-1:0] quo;
  logic [2:0]       dcnt;
  logic             div_ge;
  logic [PCT_W-1:0] quo_step;

  logic             in_range;
  logic [ADC_W-1:0] span, diff;
  logic [DIV_W-1:0] pct_num;
  logic [1:0]       wait_entry, pump_entry;
  logic             start_water;
  logic [SEC_W-1:0] tick_inc;

  assign s_tready = (state == S_IDLE);

  // shared divider step
  assign div_ge   = (rem >= dsh);
  assign quo_step = {quo[PCT_W-2:0], div_ge};

  assign in_range = (32'(in_idx) < SENSOR_COUNT) && (dry_raw > wet_raw) &&
                    (in_adc >= wet_raw) && (in_adc <= dry_raw);
  assign span     = dry_raw - wet_raw;
  assign diff     = dry_raw - in_adc;
  assign pct_num  = DIV_W'(diff) * DIV_W'(PCT_SCALE);

  assign acc_next = acc + AW'(moisture_store[walk]);

  assign wait_entry  = (wait_ticks == '0) ? PH_SAMPLING : PH_WAITING;
  assign pump_entry  = (pump_ticks == '0) ? wait_entry : PH_PUMPING;
  assign start_water = watering_active ||
                       ((average_level != '0) && (average_level <= low_trigger));
  assign tick_inc    = tick_count + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_raw      <= DRY_RAW_RST;
      wet_raw      <= WET_RAW_RST;
      low_trigger  <= LOW_TRIGGER_RST;
      target_level <= TARGET_LEVEL_RST;
      pump_ticks   <= PUMP_TICKS_RST;
      wait_ticks   <= WAIT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRY_RAW:      dry_raw      <= cfg_data[ADC_W-1:0];
        REG_WET_RAW:      wet_raw      <= cfg_data[ADC_W-1:0];
        REG_LOW_TRIGGER:  low_trigger  <= cfg_data[PCT_W-1:0];
        REG_TARGET_LEVEL: target_level <= cfg_data[PCT_W-1:0];
        REG_PUMP_TICKS:   pump_ticks   <= cfg_data[SEC_W-1:0];
        REG_WAIT_TICKS:   wait_ticks   <= cfg_data[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      average_level   <= '0;
      control_phase   <= PH_SAMPLING;
      watering_active <= 1'b0;
      tick_count      <= '0;
      m_tvalid        <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        moisture_store[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && (state != S_PUSH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_idx         <= s_tdata[1:0];
            in_adc         <= s_tdata[13:2];
            in_last        <= s_tlast;
            sample_valid   <= 1'b0;
            sample_percent <= '0;
            if (s_tuser == 1'(OP_TICK)) begin
              state <= S_TICK;
            end else if (control_phase == PH_SAMPLING) begin
              state <= S_PREP;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_PREP: begin
          acc  <= '0;
          walk <= '0;
          if (in_range) begin
            rem   <= pct_num;
            dsh   <= {1'b0, span, 6'b0};
            quo   <= '0;
            dcnt  <= 3'(DIV_STEPS - 1);
            state <= S_DIV_PCT;
          end else begin
            state <= in_last ? S_SUM : S_PUSH;
          end
        end
        S_DIV_PCT, S_DIV_AVG: begin
          rem  <= div_ge ? rem - dsh : rem;
          dsh  <= dsh >> 1;
          quo  <= quo_step;
          dcnt <= dcnt - 3'd1;
          if (dcnt == '0) begin
            if (state == S_DIV_PCT) begin
              moisture_store[WW'(in_idx)] <= quo_step;
              sample_valid                <= 1'b1;
              sample_percent              <= quo_step;
              state                       <= in_last ? S_SUM : S_PUSH;
            end else begin
              average_level <= quo_step;
              state         <= S_DECIDE;
            end
          end
        end
        S_SUM: begin
          acc  <= acc_next;
          walk <= walk + WW'(1);
          if (walk == WW'(SENSOR_COUNT - 1)) begin
            rem   <= DIV_W'(acc_next);
            dsh   <= {1'b0, ADC_W'(SENSOR_COUNT), 6'b0};
            quo   <= '0;
            dcnt  <= 3'(DIV_STEPS - 1);
            state <= S_DIV_AVG;
          end
        end
        S_DECIDE: begin
          tick_count <= '0;
          if (start_water && (average_level < target_level)) begin
            watering_active <= 1'b1;
            control_phase   <= pump_entry;
          end else if (start_water) begin
            watering_active <= 1'b0;
            control_phase   <= PH_SAMPLING;
          end else begin
            control_phase <= wait_entry;
          end
          state <= S_PUSH;
        end
        S_TICK: begin
          if (control_phase == PH_PUMPING) begin
            if (tick_inc >= pump_ticks) begin
              tick_count    <= '0;
              control_phase <= wait_entry;
            end else begin
              tick_count <= tick_inc;
            end
          end else if (control_phase == PH_WAITING) begin
            if (tick_inc >= wait_ticks) begin
              tick_count    <= '0;
              control_phase <= PH_SAMPLING;
            end else begin
              tick_count <= tick_inc;
            end
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, sample_percent, average_level, watering_active,
                         control_phase, (control_phase == PH_SAMPLING),
                         (control_phase == PH_PUMPING)};
            m_tuser  <= sample_valid;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pump_matches_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[3:2] == PH_PUMPING)))
    else $error("pump flag disagrees with phase");

  a_invalid_percent_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[18:12] == '0))
    else $error("percent set on a transaction without a stored sample");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new transaction taken while one is in work");

  a_average_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> (average_level <= PCT_W'(PCT_SCALE)))
    else $error("average above full scale");

endmodule
